>>> rtl/lwpc_pkg.sv
// Shared types and constants of the LRU write-back page cache directory.
// No dependencies.
package lwpc_pkg;

  localparam int NUM_PAGES   = 8;
  localparam int SLOT_W      = 3;
  localparam int PAGE_BYTES  = 512;
  localparam int OFF_W       = 9;
  localparam int LEN_W       = 10;
  localparam int ADDR_BITS   = 48;
  localparam int PAGE_W      = ADDR_BITS - OFF_W;
  localparam int CNT_W       = 15;
  localparam int MAX_REQUEST = 16384;
  localparam int OP_W        = 3;

  // input operation codes
  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd1;
  localparam logic [OP_W-1:0] OP_FLUSH    = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_POS  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_SIZE = 3'd4;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_FLUSH,
    CMD_SHRINK
  } cmd_kind_t;

  // one queued command from front to back
  typedef struct packed {
    cmd_kind_t              kind;
    logic [ADDR_BITS-1:0]   pos;
    logic [CNT_W-1:0]       rem;
    logic [ADDR_BITS-1:0]   size;
    logic [ADDR_BITS-1:0]   new_size;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  chunk_length;
    logic [PAGE_W-1:0] page_number;
    logic              fill_needed;
    logic [LEN_W-1:0]  fill_length;
    logic              writeback_needed;
    logic [PAGE_W-1:0] victim_page;
    logic [LEN_W-1:0]  writeback_length;
    logic              last;
  } result_t;

  // bytes of a page starting at start that lie below size (a full page if full_past_end and start is at or past size)
  function automatic logic [LEN_W-1:0] span_len(input logic [ADDR_BITS-1:0] start,
                                                input logic [ADDR_BITS-1:0] size,
                                                input logic full_past_end);
    logic [ADDR_BITS-1:0] d;
    d = size - start;
    if (start >= size) begin
      span_len = full_past_end ? LEN_W'(PAGE_BYTES) : '0;
    end else if (d < ADDR_BITS'(PAGE_BYTES)) begin
      span_len = d[LEN_W-1:0];
    end else begin
      span_len = LEN_W'(PAGE_BYTES);
    end
  endfunction

endpackage

>>> rtl/lwpc_fifo.sv
// Short command queue between front and back.
// Depends on lwpc_pkg.
module lwpc_fifo import lwpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full     = (fill == (PTR_W + 1)'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PTR_W + 1)'(push && !full) - (PTR_W + 1)'(pop && !empty);
    end
  end

endmodule

>>> rtl/lwpc_front.sv
// Front end: accepts requests, clamps reads, tracks the byte position, queues commands.
// Depends on lwpc_pkg.
module lwpc_front import lwpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      operation,
  input  logic [ADDR_BITS-1:0] position,
  input  logic [CNT_W-1:0]     count,
  input  logic [ADDR_BITS-1:0] stream_size,
  input  logic [ADDR_BITS-1:0] new_size,
  output logic                 push,
  output cmd_t                 push_data,
  input  logic                 full
);

  logic [ADDR_BITS-1:0] current_position;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     rem;
  logic [ADDR_BITS-1:0] avail;
  logic                 accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // request length after the size limit and the read clamp
  always_comb begin
    avail = stream_size - current_position;
    cnt   = (count > CNT_W'(MAX_REQUEST)) ? CNT_W'(MAX_REQUEST) : count;
    rem   = cnt;
    if (operation == OP_READ) begin
      if (current_position >= stream_size) begin
        rem = '0;
      end else if (avail < ADDR_BITS'(cnt)) begin
        rem = avail[CNT_W-1:0];
      end
    end
  end

  // classify into a queued command
  always_comb begin
    push_data.pos      = current_position;
    push_data.rem      = rem;
    push_data.size     = stream_size;
    push_data.new_size = new_size;
    push_data.kind     = CMD_READ;
    push               = 1'b0;
    case (operation)
      OP_READ: begin
        push_data.kind = CMD_READ;
        push           = accept && (rem != '0);
      end
      OP_WRITE: begin
        push_data.kind = CMD_WRITE;
        push           = accept && (rem != '0);
      end
      OP_FLUSH: begin
        push_data.kind = CMD_FLUSH;
        push           = accept;
      end
      OP_SET_SIZE: begin
        push_data.kind = CMD_SHRINK;
        push           = accept && (new_size < stream_size);
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // byte position advances by the clamped request length, or is set by set position
  always_ff @(posedge clk) begin
    if (rst) begin
      current_position <= '0;
    end else if (accept) begin
      if (operation == OP_SET_POS) begin
        current_position <= position;
      end else if (operation == OP_READ || operation == OP_WRITE) begin
        current_position <= current_position + ADDR_BITS'(rem);
      end
    end
  end

endmodule

>>> rtl/lwpc_back.sv
// Back end: directory state, chunk lookup, LRU update, flush and shrink sweeps.
// Depends on lwpc_pkg.
module lwpc_back import lwpc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    empty,
  output logic    pop,
  input  cmd_t    pop_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CHUNK,
    ST_FLUSH,
    ST_SHRINK
  } state_t;

  state_t               state;
  cmd_t                 cmd;
  logic [PAGE_W-1:0]    page_tag   [NUM_PAGES];
  logic [SLOT_W-1:0]    rank       [NUM_PAGES];
  logic [NUM_PAGES-1:0] page_valid;
  logic [NUM_PAGES-1:0] page_dirty;
  logic [SLOT_W-1:0]    sel_slot;
  logic                 sel_hit;
  logic [SLOT_W-1:0]    idx;

  logic                 out_free;
  logic [OFF_W-1:0]     off;
  logic [PAGE_W-1:0]    page;
  logic [ADDR_BITS-1:0] start;
  logic [LEN_W-1:0]     room;
  logic [LEN_W-1:0]     clen;
  logic [LEN_W-1:0]     fc;
  logic                 wr;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_slot;
  logic [SLOT_W-1:0]    lru_slot;
  logic [NUM_PAGES-1:0] dirty_above;
  logic [CNT_W-1:0]     rem_next;
  logic                 emit_chunk;
  logic                 emit_flush;
  logic                 miss_wb;
  logic                 miss_fill;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == ST_IDLE) && !empty;
  assign wr       = (cmd.kind == CMD_WRITE);

  // result launch conditions
  assign emit_chunk = (state == ST_CHUNK) && out_free;
  assign emit_flush = (state == ST_FLUSH) && page_valid[idx] && page_dirty[idx] && out_free;
  assign miss_wb    = !sel_hit && page_valid[sel_slot] && page_dirty[sel_slot];
  assign miss_fill  = !sel_hit && (!wr || (fc != '0 && (off != '0 || CNT_W'(fc) > cmd.rem)));

  // tag match and victim search
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    lru_slot = '0;
    for (int i = NUM_PAGES - 1; i >= 0; i--) begin
      if (page_valid[i] && page_tag[i] == cmd.pos[ADDR_BITS-1:OFF_W]) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (rank[i] == SLOT_W'(NUM_PAGES - 1)) lru_slot = SLOT_W'(i);
    end
  end

  // chunk geometry
  always_comb begin
    off      = cmd.pos[OFF_W-1:0];
    page     = cmd.pos[ADDR_BITS-1:OFF_W];
    start    = {page, {OFF_W{1'b0}}};
    room     = LEN_W'(PAGE_BYTES) - LEN_W'(off);
    clen     = (CNT_W'(room) > cmd.rem) ? cmd.rem[LEN_W-1:0] : room;
    fc       = span_len(start, cmd.size, 1'b0);
    rem_next = cmd.rem - CNT_W'(clen);
  end

  // dirty pages still ahead of the flush index
  always_comb begin
    for (int i = 0; i < NUM_PAGES; i++) begin
      dirty_above[i] = (SLOT_W'(i) > idx) && page_valid[i] && page_dirty[i];
    end
  end

  // sequencer, directory state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      page_valid <= '0;
      page_dirty <= '0;
      idx        <= '0;
      for (int i = 0; i < NUM_PAGES; i++) rank[i] <= SLOT_W'(i);
    end else begin
      if (emit_chunk || emit_flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            cmd <= pop_data;
            idx <= '0;
            case (pop_data.kind)
              CMD_READ, CMD_WRITE: state <= ST_LOOK;
              CMD_FLUSH:           state <= ST_FLUSH;
              default:             state <= ST_SHRINK;
            endcase
          end
        end
        ST_LOOK: begin
          sel_hit  <= hit;
          sel_slot <= hit ? hit_slot : lru_slot;
          state    <= ST_CHUNK;
        end
        ST_CHUNK: begin
          if (out_free) begin
            out_data.slot             <= sel_slot;
            out_data.offset           <= off;
            out_data.chunk_length     <= clen;
            out_data.page_number      <= page;
            out_data.fill_needed      <= miss_fill;
            out_data.fill_length      <= miss_fill ? fc : '0;
            out_data.writeback_needed <= miss_wb;
            out_data.victim_page      <= miss_wb ? page_tag[sel_slot] : '0;
            out_data.writeback_length <= miss_wb ?
              span_len({page_tag[sel_slot], {OFF_W{1'b0}}}, cmd.size, 1'b1) : '0;
            out_data.last             <= (rem_next == '0);
            if (!sel_hit) begin
              page_tag[sel_slot]   <= page;
              page_valid[sel_slot] <= 1'b1;
              page_dirty[sel_slot] <= wr;
            end else if (wr) begin
              page_dirty[sel_slot] <= 1'b1;
            end
            // move touched slot to most recent
            for (int i = 0; i < NUM_PAGES; i++) begin
              if (rank[i] < rank[sel_slot]) rank[i] <= rank[i] + 1'b1;
            end
            rank[sel_slot] <= '0;
            cmd.rem <= rem_next;
            cmd.pos <= cmd.pos + ADDR_BITS'(clen);
            state   <= (rem_next == '0) ? ST_IDLE : ST_LOOK;
          end
        end
        ST_FLUSH: begin
          if (page_valid[idx] && page_dirty[idx]) begin
            if (out_free) begin
              out_data.slot             <= idx;
              out_data.offset           <= '0;
              out_data.chunk_length     <= '0;
              out_data.page_number      <= page_tag[idx];
              out_data.fill_needed      <= 1'b0;
              out_data.fill_length      <= '0;
              out_data.writeback_needed <= 1'b1;
              out_data.victim_page      <= page_tag[idx];
              out_data.writeback_length <=
                span_len({page_tag[idx], {OFF_W{1'b0}}}, cmd.size, 1'b1);
              out_data.last             <= (dirty_above == '0);
              page_dirty[idx]           <= 1'b0;
              idx                       <= idx + 1'b1;
              if (idx == SLOT_W'(NUM_PAGES - 1)) state <= ST_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
            if (idx == SLOT_W'(NUM_PAGES - 1)) state <= ST_IDLE;
          end
        end
        ST_SHRINK: begin
          // drop pages cut off by the smaller size
          for (int i = 0; i < NUM_PAGES; i++) begin
            if (page_valid[i] && {page_tag[i], {OFF_W{1'b0}}} >= cmd.new_size) begin
              page_valid[i] <= 1'b0;
              page_dirty[i] <= 1'b0;
            end
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/lru_writeback_page_cache.sv
// LRU write-back page cache directory, top level.
// A read or write is cut into chunks, one per page touched; each chunk takes a tag lookup, then
// update and output. Flush sweeps the slots in order; set size drops pages past the new size;
// set position is handled in the front end. A 4-entry command queue parts front and back.
// Reset (rst, synchronous): position zero, all slots invalid and clean, slot i at rank i.
module lru_writeback_page_cache import lwpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // position[47:0], count[62:48], stream_size[110:63], new_size[158:111], zero pad
  input  logic [159:0] s_tdata,
  // operation[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // slot[2:0], offset[11:3], chunk_length[21:12], page_number[60:22], fill_needed[61],
  // fill_length[71:62], writeback_needed[72], victim_page[111:73],
  // writeback_length[121:112], zero pad
  output logic [127:0] m_tdata,
  output logic         m_tlast
);

  logic    push;
  cmd_t    push_data;
  logic    full;
  logic    pop;
  cmd_t    pop_data;
  logic    empty;
  result_t res;

  lwpc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .operation   (s_tuser),
    .position    (s_tdata[47:0]),
    .count       (s_tdata[62:48]),
    .stream_size (s_tdata[110:63]),
    .new_size    (s_tdata[158:111]),
    .push        (push),
    .push_data   (push_data),
    .full        (full)
  );

  lwpc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  lwpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  // pack result
  assign m_tdata = {6'b0, res.writeback_length, res.victim_page, res.writeback_needed,
                    res.fill_length, res.fill_needed, res.page_number, res.chunk_length,
                    res.offset, res.slot};
  assign m_tlast = res.last;

`ifndef SYNTHESIS
  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue overflow");
  // a fill always loads some bytes
  a_fill_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.fill_needed) |-> (res.fill_length != '0))
    else $error("fill with zero length");
  // a chunk never crosses its page
  a_chunk_in_page: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, res.offset} + res.chunk_length <= 11'(PAGE_BYTES)))
    else $error("chunk crosses page end");
`endif

endmodule
